### rtl/brf_pkg.sv
// Shared types and codes for the byte ring FIFO block.
`default_nettype none

package brf_pkg;

   localparam int FIELD_W    = 12;
   localparam int CSR_W      = 13;
   localparam int RESET_RING = 4096;

   localparam logic [1:0] FUNC_WR   = 2'd0;
   localparam logic [1:0] FUNC_RD   = 2'd1;
   localparam logic [1:0] FUNC_MORE = 2'd2;
   localparam logic [1:0] FUNC_NOP  = 2'd3;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_WR_REFUSED  = 2'd1;
   localparam logic [1:0] ST_RD_REFUSED  = 2'd2;
   localparam logic [1:0] ST_DROPPED     = 2'd3;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] valid_len;
      logic [FIELD_W-1:0] free_space;
      logic               is_empty;
      logic               is_full;
      logic               more_flag;
      logic               block_done;
      logic               rd_hit;
   } rsp_info_type;

endpackage

`default_nettype wire

### rtl/brf_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/brf_ctrl.sv
// Pointer, block counter and status logic of the byte ring FIFO.
`default_nettype none

module brf_ctrl
   import brf_pkg::*;
#(
   parameter int RING_DEPTH = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_W-1:0]              csr_wr_data,
   input  wire logic                          item_take,
   input  wire logic [1:0]                    func,
   input  wire logic [7:0]                    wr_byte,
   input  wire logic [FIELD_W-1:0]            block_len,
   input  wire logic                          first,
   input  wire logic                          more_value,
   output rsp_info_type                       info,
   output logic                               mem_we,
   output logic                               mem_re,
   output logic      [$clog2(RING_DEPTH)-1:0] mem_addr,
   output logic      [7:0]                    mem_wdata
);

   localparam int PTR_W   = $clog2(RING_DEPTH);
   localparam int CMP_W   = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;
   localparam int RESET_N = (RING_DEPTH < RESET_RING) ? RING_DEPTH : RESET_RING;

   logic [PTR_W-1:0]   last_ff, last_in;     // ring size minus one
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   cm_ptr_ff, cm_ptr_in;
   logic [PTR_W-1:0]   pd_ptr_ff, pd_ptr_in;
   logic [FIELD_W-1:0] wr_rem_ff, wr_rem_in;
   logic [FIELD_W-1:0] rd_rem_ff, rd_rem_in;
   logic               more_ff, more_in;

   logic [PTR_W-1:0]   held_cur;
   logic [PTR_W-1:0]   free_cur;
   logic [PTR_W-1:0]   held_nxt;

   logic [1:0]         status_c;
   logic               done_c;
   logic               hit_c;

   function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                            input logic [PTR_W-1:0] last);
      return (p == last) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   // wrap arithmetic: a ring of exactly 2**PTR_W adds zero
   function automatic logic [PTR_W-1:0] held(input logic [PTR_W-1:0] c,
                                             input logic [PTR_W-1:0] r,
                                             input logic [PTR_W-1:0] last);
      return PTR_W'(c - r + ((c < r) ? PTR_W'(last + 1'b1) : PTR_W'(0)));
   endfunction

   always_comb begin
      if (32'(csr_wr_data) < 2) begin
         last_in = PTR_W'(1);
      end else if (32'(csr_wr_data) > RING_DEPTH) begin
         last_in = PTR_W'(RING_DEPTH - 1);
      end else begin
         last_in = PTR_W'(csr_wr_data - 1'b1);
      end
   end

   assign held_cur = held(cm_ptr_ff, rd_ptr_ff, last_ff);
   assign free_cur = last_ff - held_cur;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      cm_ptr_in = cm_ptr_ff;
      pd_ptr_in = pd_ptr_ff;
      wr_rem_in = wr_rem_ff;
      rd_rem_in = rd_rem_ff;
      more_in   = more_ff;
      status_c  = ST_OK;
      done_c    = 1'b0;
      hit_c     = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = pd_ptr_ff;
      mem_wdata = wr_byte;
      case (func)
         FUNC_WR: begin
            if (first) begin
               // a new block abandons any open one
               pd_ptr_in = cm_ptr_ff;
               if (block_len == '0 || CMP_W'(free_cur) < CMP_W'(block_len)) begin
                  wr_rem_in = '0;
                  status_c  = ST_WR_REFUSED;
               end else begin
                  wr_rem_in = block_len;
               end
            end else if (wr_rem_ff == '0) begin
               status_c = ST_DROPPED;
            end
            if (status_c == ST_OK) begin
               mem_we    = item_take;
               mem_addr  = pd_ptr_in;
               pd_ptr_in = adv(pd_ptr_in, last_ff);
               wr_rem_in = wr_rem_in - 1'b1;
               if (wr_rem_in == '0) begin
                  cm_ptr_in = pd_ptr_in;
                  done_c    = 1'b1;
               end
            end
         end
         FUNC_RD: begin
            if (first) begin
               if (block_len == '0 || CMP_W'(held_cur) < CMP_W'(block_len)) begin
                  rd_rem_in = '0;
                  status_c  = ST_RD_REFUSED;
               end else begin
                  rd_rem_in = block_len;
               end
            end else if (rd_rem_ff == '0) begin
               status_c = ST_DROPPED;
            end
            if (status_c == ST_OK) begin
               mem_re    = item_take;
               mem_addr  = rd_ptr_ff;
               hit_c     = 1'b1;
               rd_ptr_in = adv(rd_ptr_ff, last_ff);
               rd_rem_in = rd_rem_in - 1'b1;
               if (rd_rem_in == '0) begin
                  done_c = 1'b1;
               end
            end
         end
         FUNC_MORE: begin
            more_in = more_value;
         end
         default: begin
         end
      endcase
   end

   assign held_nxt = held(cm_ptr_in, rd_ptr_in, last_ff);
   assign info     = '{status:     status_c,
                       valid_len:  FIELD_W'(held_nxt),
                       free_space: FIELD_W'(last_ff - held_nxt),
                       is_empty:   (cm_ptr_in == rd_ptr_in),
                       is_full:    (adv(cm_ptr_in, last_ff) == rd_ptr_in),
                       more_flag:  more_in,
                       block_done: done_c,
                       rd_hit:     hit_c};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= PTR_W'(RESET_N - 1);
         rd_ptr_ff <= '0;
         cm_ptr_ff <= '0;
         pd_ptr_ff <= '0;
         wr_rem_ff <= '0;
         rd_rem_ff <= '0;
         more_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         last_ff   <= last_in;
         rd_ptr_ff <= '0;
         cm_ptr_ff <= '0;
         pd_ptr_ff <= '0;
         wr_rem_ff <= '0;
         rd_rem_ff <= '0;
      end else if (item_take) begin
         rd_ptr_ff <= rd_ptr_in;
         cm_ptr_ff <= cm_ptr_in;
         pd_ptr_ff <= pd_ptr_in;
         wr_rem_ff <= wr_rem_in;
         rd_rem_ff <= rd_rem_in;
         more_ff   <= more_in;
      end
   end

   a_rd_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= last_ff) else $error("read pointer beyond ring");

   a_cm_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      cm_ptr_ff <= last_ff) else $error("commit pointer beyond ring");

   // an open write block always fits in the space left ahead of its pending pointer
   a_wr_block_fits: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(wr_rem_ff) + CMP_W'(held(pd_ptr_ff, cm_ptr_ff, last_ff)) <= CMP_W'(free_cur))
      else $error("open write block overruns free space");

   a_rd_block_fits: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(rd_rem_ff) <= CMP_W'(held_cur))
      else $error("open read block exceeds held data");

endmodule

`default_nettype wire

### rtl/byte_ring_fifo_block_transfer.sv
// Top level of the byte ring FIFO with block transfers.
//
//  channel | dir | handshake             | contents
//  req     | in  | req_tvalid/req_tready | tdata wr_byte, block_len, more_value; tuser func, first
//  rsp     | out | rsp_tvalid/rsp_tready | tdata rd_byte, lengths, flags; tuser status; tlast done
//  csr     | in  | csr_wr_en             | csr_wr_data ring size
//
//  One request per clock while no response stalls; the response follows in the next cycle,
//  with rd_byte taken from the registered read port of the byte store RAM.
//  A stalled response holds the response register and blocks new requests.
//  Reset clears pointers and block counters; the byte store is not cleared and needs no pass.
//  A ring size write empties the ring and keeps the more flag.
`default_nettype none

module byte_ring_fifo_block_transfer
   import brf_pkg::*;
#(
   parameter int RING_DEPTH = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [23:0]      req_tdata,   // wr_byte[7:0], block_len[19:8], more_value[20]
   input  wire logic [2:0]       req_tuser,   // func[1:0], first[2]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [39:0]      rsp_tdata,   // rd_byte[7:0], valid_len[19:8],
                                              // free_space[31:20], is_empty[32],
                                              // is_full[33], more_flag[34]
   output logic      [1:0]       rsp_tuser,   // status[1:0]
   output logic                  rsp_tlast,   // block_done
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   localparam int PTR_W = $clog2(RING_DEPTH);

   logic               take;
   rsp_info_type       info;
   rsp_info_type       info_ff;
   logic               out_valid_ff, out_valid_in;
   logic               mem_we;
   logic               mem_re;
   logic [PTR_W-1:0]   mem_addr;
   logic [7:0]         mem_wdata;
   logic [7:0]         mem_rdata;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   brf_ctrl #(
      .RING_DEPTH(RING_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .item_take  (take),
      .func       (req_tuser[1:0]),
      .wr_byte    (req_tdata[7:0]),
      .block_len  (req_tdata[19:8]),
      .first      (req_tuser[2]),
      .more_value (req_tdata[20]),
      .info       (info),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata)
   );

   brf_ram #(
      .WIDTH(8),
      .DEPTH(RING_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .rd_en  (mem_re),
      .addr   (mem_addr),
      .wr_data(mem_wdata),
      .rd_data(mem_rdata)
   );

   assign out_valid_in = take || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         info_ff <= info;
      end
   end

   // RAM read data holds while the response waits, since no new read is issued
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, info_ff.more_flag, info_ff.is_full, info_ff.is_empty,
                        info_ff.free_space, info_ff.valid_len,
                        info_ff.rd_hit ? mem_rdata : 8'd0};
   assign rsp_tuser  = info_ff.status;
   assign rsp_tlast  = info_ff.block_done;

endmodule

`default_nettype wire
